// ===== rtl/substring_first_match_defines.svh =====
// Assertion macros used by the checker file of the substring search block.
`ifndef SUBSTRING_FIRST_MATCH_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define SFM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked through reset as well.
`define SFM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sfm_pkg.sv =====
// Types and constants shared by the substring first-match modules.
package sfm_pkg;

   localparam int MATCH_OFFSET_W = 32;
   localparam int CSR_DATA_W     = 64;
   localparam int PAT_LEN_W      = 4;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [0:0] {
      CSR_PATTERN_LENGTH = 1'b0,
      CSR_PATTERN_BYTES  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                      found;
      logic [MATCH_OFFSET_W-1:0] match_offset;
   } rsp_payload_type;

   // One classified text byte, passed from the front to the back.
   typedef struct packed {
      logic                      hit;
      logic                      last;
      logic [MATCH_OFFSET_W-1:0] offset;
   } queue_entry_type;

endpackage

// ===== rtl/sfm_front.sv =====
// Front end: pattern registers, byte window, byte counter and window compare.
module sfm_front #(
   parameter int PATTERN_MAX = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sfm_pkg::req_payload_type req_payload,
   input  logic                    csr_write_enable,
   input  sfm_pkg::csr_index_type  csr_index,
   input  logic [sfm_pkg::CSR_DATA_W-1:0] csr_write_data,
   output logic                    push_valid,
   input  logic                    push_ready,
   output sfm_pkg::queue_entry_type push_entry
);
   import sfm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int PAT_W = PATTERN_MAX * 8;

   logic [PAT_LEN_W-1:0]   pattern_length_ff;
   logic [CSR_DATA_W-1:0]  pattern_bytes_ff;
   logic [7:0]             recent_ff [PATTERN_MAX];
   logic [7:0]             window_in [PATTERN_MAX];
   logic [OFFSET_BITS-1:0] bytes_seen_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic [OFFSET_BITS-1:0] offset_full;
   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       sel;
   logic [PAT_W-1:0]       pattern_wide;
   logic                   hit;
   logic                   accept;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // Pattern bytes beyond the register width read as zero.
   assign pattern_wide = PAT_W'(pattern_bytes_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_bytes_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[PAT_LEN_W-1:0];
            CSR_PATTERN_BYTES:  pattern_bytes_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(pattern_length_ff) > PATTERN_MAX) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = LEN_W'(pattern_length_ff);
      end
   end

   always_comb begin
      window_in[0] = req_payload.text_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         window_in[k] = recent_ff[k-1];
      end
   end

   assign count_in = (bytes_seen_ff != '1) ? bytes_seen_ff + OFFSET_BITS'(1) : bytes_seen_ff;

   // Pattern byte i lines up with the window entry len-1-i, counted from the newest.
   always_comb begin
      sel = '0;
      hit = (count_in >= OFFSET_BITS'(len_eff));
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (LEN_W'(i) < len_eff) begin
            sel = len_eff - LEN_W'(1) - LEN_W'(i);
            if (window_in[sel[IDX_W-1:0]] != pattern_wide[8*i +: 8]) begin
               hit = 1'b0;
            end
         end
      end
   end

   assign offset_full = (len_eff == '0) ? '0 : count_in - OFFSET_BITS'(len_eff);

   always_comb begin
      push_entry.hit    = hit;
      push_entry.last   = req_payload.last_byte;
      push_entry.offset = MATCH_OFFSET_W'(offset_full);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            recent_ff[k] <= window_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
      end else if (accept) begin
         bytes_seen_ff <= req_payload.last_byte ? '0 : count_in;
      end
   end

endmodule

// ===== rtl/sfm_queue.sv =====
// Short first-in first-out queue between the front and the back.
module sfm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  sfm_pkg::queue_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output sfm_pkg::queue_entry_type pop_entry
);
   import sfm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type  entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             push;
   logic             pop;

   assign push_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/sfm_back.sv =====
// Back end: decides which classified bytes give an answer and holds the result.
module sfm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  sfm_pkg::queue_entry_type pop_entry,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sfm_pkg::rsp_payload_type rsp_payload
);
   import sfm_pkg::*;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;
   logic            answer_given_ff;
   logic            answer_given_in;
   logic            out_free;
   logic            pop;
   logic            emit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = out_free;
   assign pop       = pop_valid && out_free;
   assign emit      = !answer_given_ff && (pop_entry.hit || pop_entry.last);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;
      answer_given_in = answer_given_ff;
      if (out_free) begin
         rsp_valid_in = pop && emit;
      end
      if (pop) begin
         rsp_payload_in.found        = pop_entry.hit;
         rsp_payload_in.match_offset = pop_entry.hit ? pop_entry.offset : '0;
         if (pop_entry.last) begin
            answer_given_in = 1'b0;
         end else if (pop_entry.hit) begin
            answer_given_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         answer_given_ff <= 1'b0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         answer_given_ff <= answer_given_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/substring_first_match.sv =====
// Top level of the streaming first-match substring search.
//
// This block searches a text, streamed in one byte per beat with a mark on the
// last byte, for the first occurrence of a pattern of up to PATTERN_MAX bytes.
// The pattern is set through the register port (length at index 0, bytes at
// index 1 with the first byte in bits 7 to 0) and should be written only while
// no byte is in flight inside the block; a change between two bytes of a text
// takes effect from the next byte on. Each text gives exactly one result beat:
// found with the start offset of the first match as soon as the match
// completes, or not-found with offset zero on the last byte. An empty pattern
// matches at offset zero on the first byte. The byte counter is OFFSET_BITS
// wide and saturates at its top value. The block takes one byte per clock
// cycle without a bubble while the queue has room: the window compare in the
// front end runs in the same cycle that a byte is taken, so the sustained
// rate is set by that compare and the decision in the back end. A result
// passes through the queue and the back end's output register before it shows
// on the result port. A two-entry queue between front and back lets the front
// keep taking bytes, until it is full, while a result waits on the output.
module substring_first_match #(
   parameter int PATTERN_MAX = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sfm_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sfm_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_write_enable,
   input  sfm_pkg::csr_index_type        csr_index,
   input  logic [sfm_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import sfm_pkg::*;

   // Front to queue.
   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;

   // Queue to back.
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_entry;

   // The front end shifts each byte into the window, counts bytes and tags the
   // byte with whether the pattern ends on it and where that match would start.
   sfm_front #(
      .PATTERN_MAX(PATTERN_MAX),
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   // The queue decouples the two halves so that a stalled result does not
   // stop the front end right away.
   sfm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // The back end remembers whether this text already answered, drops the
   // bytes that need no answer and holds the result beat until it is taken.
   sfm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/sfm_checker.sv =====
// Port-level checker for the substring first-match block and its bind.
`include "substring_first_match_defines.svh"

module sfm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input sfm_pkg::rsp_payload_type rsp_payload
);
   import sfm_pkg::*;

   // A result beat that is held back keeps its value.
   `SFM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "result beat changed while stalled")

   // A not-found answer always carries a zero offset.
   `SFM_ASSERT(a_not_found_zero, clock, reset, rsp_valid && !rsp_payload.found |-> rsp_payload.match_offset == '0, "not-found beat with nonzero offset")

   // Reset leaves no result pending and the input side open.
   `SFM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "block not empty after reset")

endmodule

bind substring_first_match sfm_checker u_sfm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
